@@ hw/rtl/bds_pkg.sv @@
package bds_pkg;

    localparam int FIELD_W  = 16;
    localparam int AXES     = 3;
    localparam int SLABS    = 2 * AXES;
    localparam int QDEPTH   = 2;

    typedef logic signed [FIELD_W-1:0] t_coord;
    typedef t_coord [AXES-1:0] t_vec3;

    typedef enum logic [1:0] {
        K_EMPTY,
        K_WHOLE,
        K_SLABS
    } t_kind;

    // One classified word handed from the front to the back.
    typedef struct packed {
        t_kind             kind;
        logic [SLABS-1:0]  mask;
        t_vec3             a_lo;
        t_vec3             a_hi;
        t_vec3             b_lo;
        t_vec3             b_hi;
    } t_item;

    typedef struct packed {
        t_vec3 lo;
        t_vec3 hi;
        logic  empty;
        logic  last;
    } t_piece;

endpackage

@@ hw/rtl/bds_front.sv @@
module bds_front #(
    parameter int DIMENSIONS = 3,
    parameter int COORD_BITS = 16
) (
    input  bds_pkg::t_vec3 i_a_lo,
    input  bds_pkg::t_vec3 i_a_hi,
    input  bds_pkg::t_vec3 i_b_lo,
    input  bds_pkg::t_vec3 i_b_hi,
    output bds_pkg::t_item o_item
);
    import bds_pkg::*;

    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SH   = FIELD_W - CW;
    localparam int DIMS = (DIMENSIONS < 1) ? 1 : ((DIMENSIONS > AXES) ? AXES : DIMENSIONS);

    t_vec3            a_lo;
    t_vec3            a_hi;
    t_vec3            b_lo;
    t_vec3            b_hi;
    logic             contains;
    logic             meets;
    logic [SLABS-1:0] mask;
    t_coord           lo_clip;

    // Coordinates are sign-extended from the configured width.
    always_comb begin
        for (int d = 0; d < AXES; d++) begin
            a_lo[d] = $signed(i_a_lo[d] <<< SH) >>> SH;
            a_hi[d] = $signed(i_a_hi[d] <<< SH) >>> SH;
            b_lo[d] = $signed(i_b_lo[d] <<< SH) >>> SH;
            b_hi[d] = $signed(i_b_hi[d] <<< SH) >>> SH;
        end
    end

    always_comb begin
        contains = 1'b1;
        meets    = 1'b1;
        mask     = '0;
        lo_clip  = '0;
        for (int d = 0; d < AXES; d++) begin
            if (d < DIMS) begin
                if (!($signed(a_lo[d]) >= $signed(b_lo[d]) &&
                      $signed(a_hi[d]) <= $signed(b_hi[d]))) begin
                    contains = 1'b0;
                end
                // The larger low must not pass the smaller high, so an inverted box
                // on an axis meets nothing.
                if ($signed(a_lo[d]) > $signed(b_hi[d]) ||
                    $signed(b_lo[d]) > $signed(a_hi[d]) ||
                    $signed(a_lo[d]) > $signed(a_hi[d]) ||
                    $signed(b_lo[d]) > $signed(b_hi[d])) begin
                    meets = 1'b0;
                end
                mask[2*d] = ($signed(a_lo[d]) < $signed(b_lo[d])) &&
                            ($signed(b_lo[d]) <= $signed(a_hi[d]));
                lo_clip = mask[2*d] ? b_lo[d] : a_lo[d];
                mask[2*d+1] = ($signed(lo_clip) <= $signed(b_hi[d])) &&
                              ($signed(b_hi[d]) < $signed(a_hi[d]));
            end
        end
    end

    always_comb begin
        o_item.a_lo = a_lo;
        o_item.a_hi = a_hi;
        o_item.b_lo = b_lo;
        o_item.b_hi = b_hi;
        o_item.mask = mask;
        if (contains) begin
            o_item.kind = K_EMPTY;
        end else if (!meets) begin
            o_item.kind = K_WHOLE;
        end else if (mask == '0) begin
            o_item.kind = K_EMPTY;
        end else begin
            o_item.kind = K_SLABS;
        end
    end

endmodule

@@ hw/rtl/bds_queue.sv @@
module bds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bds_pkg::t_item i_push_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output bds_pkg::t_item o_head_item
);
    import bds_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_item            r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_item  = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue count beyond its depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count missed a pop");

endmodule

@@ hw/rtl/bds_back.sv @@
module bds_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  bds_pkg::t_item  i_head_item,
    output logic            o_pop,
    output logic            o_strobe,
    output bds_pkg::t_piece o_piece
);
    import bds_pkg::*;

    logic             r_busy, n_busy;
    t_kind            r_kind;
    logic [SLABS-1:0] r_mask, n_mask;
    t_vec3            r_lo, n_lo;
    t_vec3            r_hi, n_hi;
    t_vec3            r_b_lo;
    t_vec3            r_b_hi;
    logic             r_strobe;
    t_piece           r_piece, n_piece;
    logic [2:0]       sel;
    logic             found;
    logic             emit_last;

    // The lowest remaining slab goes out first: x low, x high, y low, and so on.
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int k = 0; k < SLABS; k++) begin
            if (!found && r_mask[k]) begin
                sel   = 3'(k);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mask        = r_mask & ~(SLABS'(1) << sel);
        n_piece.lo    = r_lo;
        n_piece.hi    = r_hi;
        n_piece.empty = 1'b0;
        n_piece.last  = 1'b1;
        case (r_kind)
            K_WHOLE: begin
                n_piece.last = 1'b1;
            end
            K_SLABS: begin
                for (int d = 0; d < AXES; d++) begin
                    if (sel[2:1] == 2'(d)) begin
                        if (!sel[0]) begin
                            n_piece.hi[d] = r_b_lo[d] - 16'sd1;
                            n_lo[d]       = r_b_lo[d];
                        end else begin
                            n_piece.lo[d] = r_b_hi[d] + 16'sd1;
                            n_hi[d]       = r_b_hi[d];
                        end
                    end
                end
                n_piece.last = (n_mask == '0);
            end
            default: begin
                n_piece.lo    = '0;
                n_piece.hi    = '0;
                n_piece.empty = 1'b1;
                n_piece.last  = 1'b1;
            end
        endcase
    end

    assign emit_last = r_busy && n_piece.last;
    assign o_pop     = i_head_valid && (!r_busy || emit_last);
    assign n_busy    = o_pop || (r_busy && !emit_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_strobe <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_piece <= n_piece;
        end
        if (o_pop) begin
            r_kind <= i_head_item.kind;
            r_mask <= i_head_item.mask;
            r_lo   <= i_head_item.a_lo;
            r_hi   <= i_head_item.a_hi;
            r_b_lo <= i_head_item.b_lo;
            r_b_hi <= i_head_item.b_hi;
        end else if (r_busy) begin
            r_mask <= n_mask;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
        end
    end

    assign o_strobe = r_strobe;
    assign o_piece  = r_piece;

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_piece.empty |-> o_piece.last)
        else $error("empty result not marked as last");

    a_slab_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_kind == K_SLABS |-> r_mask != '0)
        else $error("slab word active with no slab left");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !emit_last |=> r_busy)
        else $error("word dropped before its last piece");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_strobe)
        else $error("active cycle gave no piece");

endmodule

@@ hw/rtl/box_difference_slabs_top.sv @@
// An accepted word passes the queue and the back end's word registers; its pieces
// pass a piece register. Throughput: one piece per cycle while a word is active;
// one to six per word, set by its slabs; single-piece words follow one per cycle.
// A two-word queue sits between classification and piece generation; busy is high
// while it is full. Results are strobed for one cycle and cannot be stalled.
// Reset is synchronous and active low; it clears the queue and the back end at once.
module box_difference_slabs_top #(
    parameter int DIMENSIONS = 3,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_a_lo_x,
    input  logic [15:0] i_a_lo_y,
    input  logic [15:0] i_a_lo_z,
    input  logic [15:0] i_a_hi_x,
    input  logic [15:0] i_a_hi_y,
    input  logic [15:0] i_a_hi_z,
    input  logic [15:0] i_b_lo_x,
    input  logic [15:0] i_b_lo_y,
    input  logic [15:0] i_b_lo_z,
    input  logic [15:0] i_b_hi_x,
    input  logic [15:0] i_b_hi_y,
    input  logic [15:0] i_b_hi_z,
    output logic        o_strobe,
    output logic [15:0] o_piece_lo_x,
    output logic [15:0] o_piece_lo_y,
    output logic [15:0] o_piece_lo_z,
    output logic [15:0] o_piece_hi_x,
    output logic [15:0] o_piece_hi_y,
    output logic [15:0] o_piece_hi_z,
    output logic        o_empty_result,
    output logic        o_last_piece
);
    import bds_pkg::*;

    t_vec3  a_lo;
    t_vec3  a_hi;
    t_vec3  b_lo;
    t_vec3  b_hi;
    t_item  front_item;
    t_item  head_item;
    logic   q_full;
    logic   head_valid;
    logic   pop;
    t_piece piece;

    assign a_lo = {i_a_lo_z, i_a_lo_y, i_a_lo_x};
    assign a_hi = {i_a_hi_z, i_a_hi_y, i_a_hi_x};
    assign b_lo = {i_b_lo_z, i_b_lo_y, i_b_lo_x};
    assign b_hi = {i_b_hi_z, i_b_hi_y, i_b_hi_x};

    bds_front #(
        .DIMENSIONS (DIMENSIONS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_a_lo (a_lo),
        .i_a_hi (a_hi),
        .i_b_lo (b_lo),
        .i_b_hi (b_hi),
        .o_item (front_item)
    );

    bds_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (start),
        .i_push_item  (front_item),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_item  (head_item)
    );

    bds_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_item  (head_item),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_piece      (piece)
    );

    assign busy           = q_full;
    assign o_piece_lo_x   = piece.lo[0];
    assign o_piece_lo_y   = piece.lo[1];
    assign o_piece_lo_z   = piece.lo[2];
    assign o_piece_hi_x   = piece.hi[0];
    assign o_piece_hi_y   = piece.hi[1];
    assign o_piece_hi_z   = piece.hi[2];
    assign o_empty_result = piece.empty;
    assign o_last_piece   = piece.last;

endmodule

@@ verif/box_difference_slabs_top_tb.sv @@
`timescale 1ns / 100ps

module box_difference_slabs_top_tb;
    import bds_pkg::*;

    localparam int RANDOM_PAIRS = 102;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_vec3 a_lo;
        t_vec3 a_hi;
        t_vec3 b_lo;
        t_vec3 b_hi;
    } t_box_pair;

    typedef enum {
        PAIR_OVERLAP,
        PAIR_INSIDE,
        PAIR_NOISE,
        PAIR_WIDE,
        PAIR_INVERTED
    } t_pair_shape;

    // Works out the pieces of A minus B for every accepted word and checks the
    // strobed pieces against them in order.
    class piece_ledger;
        t_piece pending_pieces[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_pieces.size();
        endfunction

        function void note_pair(t_box_pair p);
            t_coord alo[AXES];
            t_coord ahi[AXES];
            t_coord blo[AXES];
            t_coord bhi[AXES];
            t_coord lo_max;
            t_coord hi_min;
            t_piece pc;
            t_piece pieces[$];
            bit     covered;
            bit     overlaps;
            covered  = 1'b1;
            overlaps = 1'b1;
            for (int d = 0; d < AXES; d++) begin
                alo[d] = p.a_lo[d];
                ahi[d] = p.a_hi[d];
                blo[d] = p.b_lo[d];
                bhi[d] = p.b_hi[d];
            end
            for (int d = 0; d < AXES; d++) begin
                lo_max = (alo[d] > blo[d]) ? alo[d] : blo[d];
                hi_min = (ahi[d] < bhi[d]) ? ahi[d] : bhi[d];
                if (!(alo[d] >= blo[d] && ahi[d] <= bhi[d]))
                    covered = 1'b0;
                if (lo_max > hi_min)
                    overlaps = 1'b0;
            end
            if (!covered) begin
                if (!overlaps) begin
                    pc = '0;
                    for (int j = 0; j < AXES; j++) begin
                        pc.lo[j] = alo[j];
                        pc.hi[j] = ahi[j];
                    end
                    pieces = {pieces, pc};
                end else begin
                    // Peel the slab below B, then the slab above it, shrinking A
                    // onto B along each axis in turn.
                    for (int d = 0; d < AXES; d++) begin
                        if (alo[d] < blo[d] && blo[d] <= ahi[d]) begin
                            pc = '0;
                            for (int j = 0; j < AXES; j++) begin
                                pc.lo[j] = alo[j];
                                pc.hi[j] = ahi[j];
                            end
                            pc.hi[d] = blo[d] - 16'sd1;
                            pieces = {pieces, pc};
                            alo[d] = blo[d];
                        end
                        if (alo[d] <= bhi[d] && bhi[d] < ahi[d]) begin
                            pc = '0;
                            for (int j = 0; j < AXES; j++) begin
                                pc.lo[j] = alo[j];
                                pc.hi[j] = ahi[j];
                            end
                            pc.lo[d] = bhi[d] + 16'sd1;
                            pieces = {pieces, pc};
                            ahi[d] = bhi[d];
                        end
                    end
                end
            end
            if (pieces.size() == 0) begin
                pc = '0;
                pc.empty = 1'b1;
                pieces = {pieces, pc};
            end
            pieces[pieces.size() - 1].last = 1'b1;
            pending_pieces = {pending_pieces, pieces};
        endfunction

        function void check_piece(t_piece got);
            t_piece want;
            string  axis_name;
            axis_name = "xyz";
            if (pending_pieces.size() == 0) begin
                $display("%0t: unexpected piece lo=(%0d,%0d,%0d) hi=(%0d,%0d,%0d)",
                         $time, got.lo[0], got.lo[1], got.lo[2],
                         got.hi[0], got.hi[1], got.hi[2]);
                errors++;
                return;
            end
            want = pending_pieces[0];
            pending_pieces.delete(0);
            for (int d = 0; d < AXES; d++) begin
                if (got.lo[d] !== want.lo[d]) begin
                    $display("%0t: piece_lo_%s expected %0d actual %0d", $time,
                             axis_name.substr(d, d), want.lo[d], got.lo[d]);
                    errors++;
                end
                if (got.hi[d] !== want.hi[d]) begin
                    $display("%0t: piece_hi_%s expected %0d actual %0d", $time,
                             axis_name.substr(d, d), want.hi[d], got.hi[d]);
                    errors++;
                end
            end
            if (got.empty !== want.empty) begin
                $display("%0t: empty_result expected %0b actual %0b", $time,
                         want.empty, got.empty);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_piece expected %0b actual %0b", $time,
                         want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_a_lo_x, i_a_lo_y, i_a_lo_z;
    logic [15:0] i_a_hi_x, i_a_hi_y, i_a_hi_z;
    logic [15:0] i_b_lo_x, i_b_lo_y, i_b_lo_z;
    logic [15:0] i_b_hi_x, i_b_hi_y, i_b_hi_z;
    logic        o_strobe;
    logic [15:0] o_piece_lo_x, o_piece_lo_y, o_piece_lo_z;
    logic [15:0] o_piece_hi_x, o_piece_hi_y, o_piece_hi_z;
    logic        o_empty_result;
    logic        o_last_piece;

    piece_ledger ledger;
    int          cycles;

    box_difference_slabs_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_a_lo_x       (i_a_lo_x),
        .i_a_lo_y       (i_a_lo_y),
        .i_a_lo_z       (i_a_lo_z),
        .i_a_hi_x       (i_a_hi_x),
        .i_a_hi_y       (i_a_hi_y),
        .i_a_hi_z       (i_a_hi_z),
        .i_b_lo_x       (i_b_lo_x),
        .i_b_lo_y       (i_b_lo_y),
        .i_b_lo_z       (i_b_lo_z),
        .i_b_hi_x       (i_b_hi_x),
        .i_b_hi_y       (i_b_hi_y),
        .i_b_hi_z       (i_b_hi_z),
        .o_strobe       (o_strobe),
        .o_piece_lo_x   (o_piece_lo_x),
        .o_piece_lo_y   (o_piece_lo_y),
        .o_piece_lo_z   (o_piece_lo_z),
        .o_piece_hi_x   (o_piece_hi_x),
        .o_piece_hi_y   (o_piece_hi_y),
        .o_piece_hi_z   (o_piece_hi_z),
        .o_empty_result (o_empty_result),
        .o_last_piece   (o_last_piece)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The counter is a two-state int, so it starts from zero.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pieces cannot be held off, so every strobe is taken as it comes.
    always @(posedge i_clk) begin
        t_piece got;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            got.lo[0] = o_piece_lo_x;
            got.lo[1] = o_piece_lo_y;
            got.lo[2] = o_piece_lo_z;
            got.hi[0] = o_piece_hi_x;
            got.hi[1] = o_piece_hi_y;
            got.hi[2] = o_piece_hi_z;
            got.empty = o_empty_result;
            got.last  = o_last_piece;
            ledger.check_piece(got);
        end
    end

    function automatic t_vec3 vec(int x, int y, int z);
        t_vec3 v;
        v[0] = x[15:0];
        v[1] = y[15:0];
        v[2] = z[15:0];
        return v;
    endfunction

    function automatic t_box_pair pair_of(t_vec3 alo, t_vec3 ahi, t_vec3 blo, t_vec3 bhi);
        t_box_pair p;
        p.a_lo = alo;
        p.a_hi = ahi;
        p.b_lo = blo;
        p.b_hi = bhi;
        return p;
    endfunction

    function automatic t_box_pair build_pair(t_pair_shape shape);
        t_box_pair p;
        int        centre;
        int        lo;
        int        hi;
        int        inner_lo;
        int        inner_hi;
        t_coord    u;
        t_coord    v;
        t_coord    swap;
        int        axis;
        for (int d = 0; d < AXES; d++) begin
            centre = int'($urandom_range(0, 65400)) - 32700;
            case (shape)
                PAIR_OVERLAP, PAIR_INVERTED: begin
                    lo = centre + int'($urandom_range(0, 40)) - 20;
                    hi = lo + int'($urandom_range(0, 40));
                    p.a_lo[d] = lo[15:0];
                    p.a_hi[d] = hi[15:0];
                    lo = centre + int'($urandom_range(0, 60)) - 30;
                    hi = lo + int'($urandom_range(0, 40));
                    p.b_lo[d] = lo[15:0];
                    p.b_hi[d] = hi[15:0];
                end
                PAIR_INSIDE: begin
                    lo = centre - int'($urandom_range(0, 30));
                    hi = centre + int'($urandom_range(0, 30));
                    inner_lo = lo + int'($urandom_range(0, centre - lo));
                    inner_hi = centre + int'($urandom_range(0, hi - centre));
                    p.b_lo[d] = lo[15:0];
                    p.b_hi[d] = hi[15:0];
                    p.a_lo[d] = inner_lo[15:0];
                    p.a_hi[d] = inner_hi[15:0];
                end
                PAIR_NOISE: begin
                    p.a_lo[d] = 16'($urandom);
                    p.a_hi[d] = 16'($urandom);
                    p.b_lo[d] = 16'($urandom);
                    p.b_hi[d] = 16'($urandom);
                end
                default: begin
                    u = 16'($urandom);
                    v = 16'($urandom);
                    p.a_lo[d] = (u < v) ? u : v;
                    p.a_hi[d] = (u < v) ? v : u;
                    u = 16'($urandom);
                    v = 16'($urandom);
                    p.b_lo[d] = (u < v) ? u : v;
                    p.b_hi[d] = (u < v) ? v : u;
                end
            endcase
        end
        if (shape == PAIR_INVERTED) begin
            axis = $urandom_range(0, AXES - 1);
            swap = p.a_lo[axis];
            p.a_lo[axis] = p.a_hi[axis];
            p.a_hi[axis] = swap;
        end
        return p;
    endfunction

    function automatic t_pair_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return PAIR_OVERLAP;
        else if (r < 72)
            return PAIR_INSIDE;
        else if (r < 82)
            return PAIR_NOISE;
        else if (r < 92)
            return PAIR_WIDE;
        return PAIR_INVERTED;
    endfunction

    // Holds start high until busy is seen low at a rising edge.
    task automatic send_pair(input t_box_pair p);
        i_a_lo_x <= p.a_lo[0];
        i_a_lo_y <= p.a_lo[1];
        i_a_lo_z <= p.a_lo[2];
        i_a_hi_x <= p.a_hi[0];
        i_a_hi_y <= p.a_hi[1];
        i_a_hi_z <= p.a_hi[2];
        i_b_lo_x <= p.b_lo[0];
        i_b_lo_y <= p.b_lo[1];
        i_b_lo_z <= p.b_lo[2];
        i_b_hi_x <= p.b_hi[0];
        i_b_hi_y <= p.b_hi[1];
        i_b_hi_z <= p.b_hi[2];
        start    <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        ledger.note_pair(p);
    endtask

    task automatic idle_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pieces();
        start <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_box_pair directed[$];
        ledger   = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_a_lo_x = '0;
        i_a_lo_y = '0;
        i_a_lo_z = '0;
        i_a_hi_x = '0;
        i_a_hi_y = '0;
        i_a_hi_z = '0;
        i_b_lo_x = '0;
        i_b_lo_y = '0;
        i_b_lo_z = '0;
        i_b_hi_x = '0;
        i_b_hi_y = '0;
        i_b_hi_z = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A inside B, and A equal to B over the whole range: both give the empty word.
        directed = {directed, pair_of(vec(0, 0, 0), vec(10, 10, 10),
                                      vec(-5, -5, -5), vec(20, 20, 20))};
        directed = {directed, pair_of(vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                                      vec(-32768, -32768, -32768), vec(32767, 32767, 32767))};
        // A single point of B carved from the full range leaves all six slabs; a corner point leaves three.
        directed = {directed, pair_of(vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                                      vec(0, 0, 0), vec(0, 0, 0))};
        directed = {directed, pair_of(vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                                      vec(-32768, -32768, -32768),
                                      vec(-32768, -32768, -32768))};
        directed = {directed, pair_of(vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                                      vec(32767, 32767, 32767), vec(32767, 32767, 32767))};
        // Disjoint by one, then touching on one coordinate.
        directed = {directed, pair_of(vec(0, 0, 0), vec(9, 10, 10),
                                      vec(10, -5, -5), vec(20, 20, 20))};
        directed = {directed, pair_of(vec(0, 0, 0), vec(10, 10, 10),
                                      vec(10, -5, -5), vec(20, 20, 20))};
        // One slab at a time on y and on z, and both slabs on x only.
        directed = {directed, pair_of(vec(0, -8, 0), vec(10, 10, 10),
                                      vec(-5, 0, -5), vec(20, 20, 20))};
        directed = {directed, pair_of(vec(0, 0, 0), vec(10, 10, 30),
                                      vec(-5, -5, -5), vec(20, 20, 20))};
        directed = {directed, pair_of(vec(0, 0, 0), vec(40, 10, 10),
                                      vec(5, -5, -5), vec(20, 20, 20))};
        // Inverted A outside B, inverted A inside B, and an inverted B.
        directed = {directed, pair_of(vec(10, 0, 0), vec(0, 10, 10),
                                      vec(20, -5, -5), vec(30, 20, 20))};
        directed = {directed, pair_of(vec(5, 5, 5), vec(3, 3, 3),
                                      vec(0, 0, 0), vec(10, 10, 10))};
        directed = {directed, pair_of(vec(0, 0, 0), vec(10, 10, 10),
                                      vec(8, 8, 8), vec(2, 2, 2))};
        directed = {directed, pair_of(vec(-100, -100, -100), vec(-1, -1, -1),
                                      vec(-50, -60, -70), vec(-40, -30, -20))};
        directed = {directed, pair_of(vec(7, -7, 7), vec(7, -7, 7),
                                      vec(7, -7, 7), vec(7, -7, 7))};
        directed = {directed, pair_of(vec(7, -7, 7), vec(7, -7, 7),
                                      vec(8, -7, 7), vec(9, -7, 7))};
        directed = {directed, pair_of(vec(32767, 32767, 32767), vec(32767, 32767, 32767),
                                      vec(-32768, -32768, -32768),
                                      vec(32766, 32766, 32766))};
        directed = {directed, pair_of(vec(-32768, 0, 0), vec(32767, 5, 5),
                                      vec(-32767, 0, 0), vec(32766, 5, 5))};

        foreach (directed[k]) begin
            send_pair(directed[k]);
            idle_sender();
        end

        // Let the back end empty completely before the random part.
        drain_pieces();
        repeat (3) @(posedge i_clk);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            send_pair(build_pair(pick_shape()));
            if (n == RANDOM_PAIRS / 2) begin
                drain_pieces();
                repeat (3) @(posedge i_clk);
            end else if (n < 30 || n >= 60) begin
                idle_sender();
            end
        end

        drain_pieces();
        repeat (10) @(posedge i_clk);
        if (ledger.pending() != 0) begin
            $display("%0t: %0d expected pieces never arrived", $time, ledger.pending());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bds_pkg.sv
hw/rtl/bds_front.sv
hw/rtl/bds_queue.sv
hw/rtl/bds_back.sv
hw/rtl/box_difference_slabs_top.sv
verif/box_difference_slabs_top_tb.sv
